// File: src/wavelet_matrix_access_rank_macros.svh
// Assertion macros shared by the wavelet matrix RTL.
// Depends on a clk and an arst_n in the scope of each use.
`ifndef WAVELET_MATRIX_ACCESS_RANK_MACROS_SVH
`define WAVELET_MATRIX_ACCESS_RANK_MACROS_SVH

// same-cycle implication
`define WMAR_ASSERT_IMP(label, a, b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("wmar assertion failed");

// next-cycle implication
`define WMAR_ASSERT_NXT(label, a, b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("wmar assertion failed");

`endif

// File: src/wmar_pkg.sv
// Types, constants and helpers for the wavelet matrix block.
// No dependencies.
package wmar_pkg;
	localparam int MAX_ELEMENTS = 1024;
	localparam int VALUE_BITS   = 16;
	localparam int POS_W        = 11;
	localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
	localparam int LVL_W        = $clog2(VALUE_BITS);
	localparam int LCNT_W       = LVL_W + 1;

	typedef enum logic [1:0] {
		KIND_LOAD   = 2'd0,
		KIND_ACCESS = 2'd1,
		KIND_RANK   = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_BAD_RANGE = 2'd1,
		STAT_NOT_BUILT = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CNT,
		ST_PART,
		ST_ACC_RD,
		ST_ACC_EV,
		ST_RK_L,
		ST_RK_R,
		ST_RK_EV,
		ST_DONE
	} state_t;

	// bit length of a value, at least one
	function automatic logic [LCNT_W-1:0] level_len(input logic [VALUE_BITS-1:0] v);
		logic [LCNT_W-1:0] n;
		n = LCNT_W'(1);
		for (int i = 1; i < VALUE_BITS; i++) begin
			if (v[i]) n = LCNT_W'(i + 1);
		end
		return n;
	endfunction
endpackage

// File: src/wmar_req_if.sv
// Request channel of the wavelet matrix block.
// Depends on wmar_pkg for field widths.
interface wmar_req_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    kind;
	logic [wmar_pkg::VALUE_BITS-1:0] value;
	logic [wmar_pkg::POS_W-1:0]    position;
	logic [wmar_pkg::POS_W-1:0]    right_end;
	logic                          last;

	modport source (output valid, kind, value, position, right_end, last, input ready);
	modport sink (input valid, kind, value, position, right_end, last, output ready);
endinterface

// File: src/wmar_rsp_if.sv
// Response channel of the wavelet matrix block.
// Depends on wmar_pkg for field widths.
interface wmar_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [wmar_pkg::VALUE_BITS-1:0] answer;
	logic [1:0]                      status;

	modport source (output valid, answer, status, input ready);
	modport sink (input valid, answer, status, output ready);
endinterface

// File: src/wavelet_matrix_access_rank.sv
// Wavelet matrix with access and rank queries. A load is taken in the idle state and leaves
// the block idle, but the load marked last starts a build: one pass over the work RAM per
// level for the bit plane and one for the stable partition. Once taken, an access makes one
// level-RAM read per level and a rank two, through a single read port, before the response
// is handed over; an error or an out-of-range symbol goes straight to the hand-over. The
// response is valid from the edge that ends the busy stretch. The block takes no request
// while busy; a finished response sits in an output register, so the next request is taken
// while it waits, and a second response stalls the block until the first is taken. No
// clearing pass after reset.
// Depends on wmar_pkg, wmar_req_if, wmar_rsp_if, wmar_ram and the macros header.
`include "wavelet_matrix_access_rank_macros.svh"

module wavelet_matrix_access_rank (
	input logic        clk,
	input logic        arst_n,
	wmar_req_if.sink   req,
	wmar_rsp_if.source rsp
);
	localparam int AW = wmar_pkg::ADDR_W;
	localparam int PW = wmar_pkg::POS_W;
	localparam int VB = wmar_pkg::VALUE_BITS;
	localparam int LW = wmar_pkg::LVL_W;
	localparam int CW = wmar_pkg::LCNT_W;

	wmar_pkg::state_t st_q, st_d;

	logic [PW-1:0] cnt_q, j_q, pos_s1, ones_q, zpos_q, opos_q, k_q, l_q, r_q, ones_l_q;
	logic [CW-1:0] lv_q;
	logic [LW-1:0] idx_q;
	logic [VB-1:0] or_q, val_q, ans_q, ans_out_q;
	logic          built_q, cur_q, vld_s1, ov_q, lfull_s1, rfull_s1;
	wmar_pkg::status_t stat_q, stat_out_q;
	logic [PW-1:0] zt_q [VB];

	logic            wrk_we, lvl_we;
	logic [AW:0]     wrk_waddr, wrk_raddr;
	logic [VB-1:0]   wrk_wdata, wrk_rdata;
	logic [AW+LW-1:0] lvl_waddr, lvl_raddr;
	logic [PW:0]     lvl_wdata, lvl_rdata;

	wmar_ram #(.WIDTH(VB), .DEPTH(2 * wmar_pkg::MAX_ELEMENTS)) u_work (
		.clk(clk), .we(wrk_we), .waddr(wrk_waddr), .wdata(wrk_wdata),
		.raddr(wrk_raddr), .rdata(wrk_rdata)
	);

	wmar_ram #(.WIDTH(PW + 1), .DEPTH(VB * wmar_pkg::MAX_ELEMENTS)) u_level (
		.clk(clk), .we(lvl_we), .waddr(lvl_waddr), .wdata(lvl_wdata),
		.raddr(lvl_raddr), .rdata(lvl_rdata)
	);

	// shared datapath terms
	logic [CW-1:0] sh;
	logic          pbit, sbit, last_lvl, pass_end, issue, acc, out_free;
	logic [PW-1:0] eff, zt_cur, ones_full, ones_r, l_new, r_new;
	logic [VB-1:0] or_new;
	logic          room, acc_bad, rk_bad, wide;

	assign sh        = lv_q - CW'(1) - CW'(idx_q);
	assign pbit      = wrk_rdata[sh[LW-1:0]];
	assign sbit      = val_q[sh[LW-1:0]];
	assign last_lvl  = (CW'(idx_q) == lv_q - CW'(1));
	assign pass_end  = (j_q == cnt_q) && !vld_s1;
	assign issue     = ((st_q == wmar_pkg::ST_CNT) || (st_q == wmar_pkg::ST_PART))
	                   && (j_q < cnt_q);
	assign acc       = req.valid && req.ready;
	assign out_free  = !ov_q || rsp.ready;
	assign eff       = built_q ? '0 : cnt_q;
	assign room      = eff < PW'(wmar_pkg::MAX_ELEMENTS);
	// start the running OR of the values afresh with the first value of a set
	assign or_new    = ((eff == '0) ? '0 : or_q) | (room ? req.value : '0);
	assign acc_bad   = req.position >= cnt_q;
	assign rk_bad    = (req.position > req.right_end) || (req.right_end > cnt_q);
	assign wide      = (req.value >> lv_q) != '0;
	assign zt_cur    = zt_q[idx_q];
	assign ones_full = cnt_q - zt_cur;
	assign ones_r    = rfull_s1 ? ones_full : lvl_rdata[PW-1:0];
	assign l_new     = sbit ? zt_cur + ones_l_q : l_q - ones_l_q;
	assign r_new     = sbit ? zt_cur + ones_r : r_q - ones_r;

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			wmar_pkg::ST_IDLE: begin
				if (acc) begin
					unique case (wmar_pkg::kind_t'(req.kind))
						wmar_pkg::KIND_LOAD: if (req.last) st_d = wmar_pkg::ST_CNT;
						wmar_pkg::KIND_ACCESS: begin
							st_d = (!built_q || acc_bad) ? wmar_pkg::ST_DONE
							                              : wmar_pkg::ST_ACC_RD;
						end
						wmar_pkg::KIND_RANK: begin
							st_d = (!built_q || rk_bad || wide) ? wmar_pkg::ST_DONE
							                                     : wmar_pkg::ST_RK_L;
						end
						default: st_d = wmar_pkg::ST_IDLE;
					endcase
				end
			end
			wmar_pkg::ST_CNT: if (pass_end) st_d = wmar_pkg::ST_PART;
			wmar_pkg::ST_PART: begin
				if (pass_end) st_d = last_lvl ? wmar_pkg::ST_IDLE : wmar_pkg::ST_CNT;
			end
			wmar_pkg::ST_ACC_RD: st_d = wmar_pkg::ST_ACC_EV;
			wmar_pkg::ST_ACC_EV: st_d = last_lvl ? wmar_pkg::ST_DONE : wmar_pkg::ST_ACC_RD;
			wmar_pkg::ST_RK_L:   st_d = wmar_pkg::ST_RK_R;
			wmar_pkg::ST_RK_R:   st_d = wmar_pkg::ST_RK_EV;
			wmar_pkg::ST_RK_EV:  st_d = last_lvl ? wmar_pkg::ST_DONE : wmar_pkg::ST_RK_L;
			wmar_pkg::ST_DONE:   if (out_free) st_d = wmar_pkg::ST_IDLE;
			default:             st_d = wmar_pkg::ST_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		wrk_we    = 1'b0;
		wrk_waddr = {1'b0, eff[AW-1:0]};
		wrk_wdata = req.value;
		wrk_raddr = {cur_q, j_q[AW-1:0]};
		lvl_we    = 1'b0;
		lvl_waddr = {idx_q, pos_s1[AW-1:0]};
		lvl_wdata = {pbit, ones_q};
		lvl_raddr = {idx_q, k_q[AW-1:0]};
		unique case (st_q)
			wmar_pkg::ST_IDLE: begin
				wrk_we = acc && (wmar_pkg::kind_t'(req.kind) == wmar_pkg::KIND_LOAD) && room;
			end
			wmar_pkg::ST_CNT: lvl_we = vld_s1;
			wmar_pkg::ST_PART: begin
				wrk_we    = vld_s1;
				wrk_waddr = {~cur_q, pbit ? opos_q[AW-1:0] : zpos_q[AW-1:0]};
				wrk_wdata = wrk_rdata;
			end
			wmar_pkg::ST_RK_L: lvl_raddr = {idx_q, l_q[AW-1:0]};
			wmar_pkg::ST_RK_R: lvl_raddr = {idx_q, r_q[AW-1:0]};
			default: ;
		endcase
	end

	assign req.ready  = (st_q == wmar_pkg::ST_IDLE);
	assign rsp.valid  = ov_q;
	assign rsp.answer = ans_out_q;
	assign rsp.status = stat_out_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= wmar_pkg::ST_IDLE;
			cnt_q   <= '0;
			lv_q    <= CW'(1);
			built_q <= 1'b0;
			ov_q    <= 1'b0;
			cur_q   <= 1'b0;
			idx_q   <= '0;
			j_q     <= '0;
			vld_s1  <= 1'b0;
		end else begin
			st_q   <= st_d;
			vld_s1 <= issue;
			if (issue) j_q <= j_q + PW'(1);
			if ((st_q == wmar_pkg::ST_DONE) && out_free) ov_q <= 1'b1;
			else if (rsp.ready) ov_q <= 1'b0;
			unique case (st_q)
				wmar_pkg::ST_IDLE: begin
					idx_q <= '0;
					if (acc && (wmar_pkg::kind_t'(req.kind) == wmar_pkg::KIND_LOAD)) begin
						built_q <= 1'b0;
						cnt_q   <= room ? eff + PW'(1) : eff;
						if (req.last) begin
							lv_q  <= wmar_pkg::level_len(or_new);
							cur_q <= 1'b0;
							j_q   <= '0;
						end
					end
				end
				wmar_pkg::ST_CNT: if (pass_end) j_q <= '0;
				wmar_pkg::ST_PART: begin
					if (pass_end) begin
						j_q   <= '0;
						cur_q <= ~cur_q;
						idx_q <= idx_q + LW'(1);
						if (last_lvl) built_q <= 1'b1;
					end
				end
				wmar_pkg::ST_ACC_EV, wmar_pkg::ST_RK_EV: idx_q <= idx_q + LW'(1);
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		pos_s1 <= j_q;
		unique case (st_q)
			wmar_pkg::ST_IDLE: begin
				ones_q <= '0;
				k_q    <= req.position;
				l_q    <= req.position;
				r_q    <= req.right_end;
				val_q  <= req.value;
				ans_q  <= '0;
				if (!built_q) stat_q <= wmar_pkg::STAT_NOT_BUILT;
				else if ((wmar_pkg::kind_t'(req.kind) == wmar_pkg::KIND_ACCESS) ? acc_bad
				                                                                : rk_bad)
					stat_q <= wmar_pkg::STAT_BAD_RANGE;
				else stat_q <= wmar_pkg::STAT_OK;
				if (acc && (wmar_pkg::kind_t'(req.kind) == wmar_pkg::KIND_LOAD))
					or_q <= or_new;
			end
			wmar_pkg::ST_CNT: begin
				if (vld_s1) ones_q <= ones_q + PW'(pbit);
				if (pass_end) begin
					zt_q[idx_q] <= cnt_q - ones_q;
					opos_q      <= cnt_q - ones_q;
					zpos_q      <= '0;
				end
			end
			wmar_pkg::ST_PART: begin
				if (vld_s1) begin
					if (pbit) opos_q <= opos_q + PW'(1);
					else zpos_q <= zpos_q + PW'(1);
				end
				if (pass_end) ones_q <= '0;
			end
			wmar_pkg::ST_ACC_EV: begin
				if (lvl_rdata[PW]) begin
					ans_q <= ans_q | (VB'(1) << sh);
					k_q   <= zt_cur + lvl_rdata[PW-1:0];
				end else begin
					k_q <= k_q - lvl_rdata[PW-1:0];
				end
			end
			wmar_pkg::ST_RK_L: lfull_s1 <= (l_q == cnt_q);
			wmar_pkg::ST_RK_R: begin
				rfull_s1 <= (r_q == cnt_q);
				ones_l_q <= lfull_s1 ? ones_full : lvl_rdata[PW-1:0];
			end
			wmar_pkg::ST_RK_EV: begin
				l_q <= l_new;
				r_q <= r_new;
				if (last_lvl) ans_q <= VB'(r_new - l_new);
			end
			wmar_pkg::ST_DONE: begin
				if (out_free) begin
					ans_out_q  <= ans_q;
					stat_out_q <= stat_q;
				end
			end
			default: ;
		endcase
	end

	`WMAR_ASSERT_IMP(a_lv_range, built_q, (lv_q >= CW'(1)) && (lv_q <= CW'(VB)))
	`WMAR_ASSERT_IMP(a_cnt_max, 1'b1, cnt_q <= PW'(wmar_pkg::MAX_ELEMENTS))
	`WMAR_ASSERT_IMP(a_pass_idx, issue || vld_s1, j_q <= cnt_q)
	`WMAR_ASSERT_NXT(a_done_hold, (st_q == wmar_pkg::ST_DONE) && ov_q && !rsp.ready,
		st_q == wmar_pkg::ST_DONE)
endmodule

// File: src/wmar_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wmar_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// File: test/wavelet_matrix_access_rank_tb_if.sv
// Holds wmar_tb_pkg with the predictor's result type; the testbench drives wmar_req_if and
// wmar_rsp_if from the RTL source tree. Depends on wmar_pkg.
`timescale 1ns / 1ps
package wmar_tb_pkg;
	import wmar_pkg::*;
	typedef struct packed {
		logic [VALUE_BITS-1:0] answer;
		status_t               status;
	} query_result_t;
endpackage

// File: test/wavelet_matrix_access_rank_tb.sv
// Testbench for the wavelet matrix block: drives loads, builds, access and rank queries,
// predicts each response and checks it in order. Depends on wmar_pkg, the request and
// response interfaces and wmar_tb_pkg.
`timescale 1ns / 1ps
module wavelet_matrix_access_rank_tb;
	import wmar_pkg::*;
	import wmar_tb_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #10 clk = ~clk;

	wmar_req_if req ();
	wmar_rsp_if rsp ();

	wavelet_matrix_access_rank dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	// predictor state: the loaded values in original order are enough to answer queries
	logic [VALUE_BITS-1:0] held_values [MAX_ELEMENTS];
	int unsigned           held_count = 0;
	int unsigned           depth = 1;
	bit                    is_built = 0;
	query_result_t         pending_results [$];
	bit                    failed = 0;
	bit                    rsp_quiet = 0;
	int                    rsp_hold = 0;
	bit                    no_idle = 0;

	function automatic int unsigned bit_len(logic [VALUE_BITS-1:0] v);
		int unsigned n;
		n = 1;
		for (int i = 0; i < VALUE_BITS; i++)
			if (v[i]) n = i + 1;
		return n;
	endfunction

	function automatic void predict(kind_t k, logic [VALUE_BITS-1:0] v,
			logic [POS_W-1:0] p, logic [POS_W-1:0] r, logic lst);
		query_result_t res;
		int unsigned cnt;
		if (k == KIND_NONE) return;
		if (k == KIND_LOAD) begin
			if (is_built) begin
				is_built = 0;
				held_count = 0;
			end
			if (held_count < MAX_ELEMENTS) begin
				held_values[held_count] = v;
				held_count++;
			end
			if (lst) begin
				depth = 1;
				for (int j = 0; j < held_count; j++)
					if (bit_len(held_values[j]) > depth) depth = bit_len(held_values[j]);
				is_built = 1;
			end
			return;
		end
		res.answer = '0;
		res.status = STAT_OK;
		if (!is_built) res.status = STAT_NOT_BUILT;
		else if (k == KIND_ACCESS) begin
			if (p >= held_count) res.status = STAT_BAD_RANGE;
			else res.answer = held_values[p];
		end else begin
			if (p > r || r > held_count) res.status = STAT_BAD_RANGE;
			else if ((32'(v) >> depth) == 0) begin
				cnt = 0;
				for (int j = p; j < r; j++)
					if (held_values[j] == v) cnt++;
				res.answer = (cnt > 65535) ? 16'hFFFF : cnt[15:0];
			end
		end
		pending_results.insert(pending_results.size(), res);
	endfunction

	// valid stays high after a transaction so that the next one follows back to back;
	// drop it only when idling or draining
	task automatic send_item(kind_t k, logic [VALUE_BITS-1:0] v, logic [POS_W-1:0] p,
			logic [POS_W-1:0] r, logic lst);
		if (!no_idle && $urandom_range(99) < 15) begin
			req.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 15);
		end
		req.valid <= 1'b1;
		req.kind <= k;
		req.value <= v;
		req.position <= p;
		req.right_end <= r;
		req.last <= lst;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		predict(k, v, p, r, lst);
	endtask

	task automatic load_set(int unsigned n, int unsigned maxv);
		for (int i = 0; i < n; i++)
			send_item(KIND_LOAD, 16'($urandom_range(maxv)), '0, '0, i == n - 1);
	endtask

	task automatic random_query();
		int unsigned a, b;
		a = $urandom_range(held_count + 2);
		b = $urandom_range(held_count + 2);
		if ($urandom_range(9) < 8 && a > b) {a, b} = {b, a};
		if ($urandom_range(1))
			send_item(KIND_ACCESS, 16'($urandom), 11'(a), 11'($urandom), 1'($urandom));
		else if ($urandom_range(9) < 7 && held_count > 0)
			send_item(KIND_RANK, held_values[$urandom_range(held_count - 1)],
				11'(a), 11'(b), 1'($urandom));
		else
			send_item(KIND_RANK, 16'($urandom), 11'(a), 11'(b), 1'($urandom));
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed();
		send_item(KIND_ACCESS, '0, '0, '0, 1'b0);
		send_item(KIND_RANK, '0, '0, '0, 1'b0);
		send_item(KIND_NONE, 16'hFFFF, 11'h7FF, 11'h7FF, 1'b1);
		send_item(KIND_LOAD, 16'hFFFF, '0, '0, 1'b0);
		send_item(KIND_LOAD, 16'h0000, '0, '0, 1'b0);
		send_item(KIND_LOAD, 16'hFFFF, '0, '0, 1'b0);
		send_item(KIND_LOAD, 16'h8001, '0, '0, 1'b1);
		send_item(KIND_ACCESS, '0, 11'd0, '0, 1'b1);
		send_item(KIND_ACCESS, '0, 11'd3, '0, 1'b0);
		send_item(KIND_ACCESS, '0, 11'd4, '0, 1'b0);
		send_item(KIND_ACCESS, '0, 11'h7FF, '0, 1'b0);
		send_item(KIND_RANK, 16'hFFFF, 11'd0, 11'd4, 1'b0);
		send_item(KIND_RANK, 16'h0000, 11'd0, 11'd4, 1'b0);
		send_item(KIND_RANK, 16'hFFFF, 11'd2, 11'd2, 1'b0);
		send_item(KIND_RANK, 16'hFFFF, 11'd3, 11'd2, 1'b0);
		send_item(KIND_RANK, 16'hFFFF, 11'd0, 11'd5, 1'b0);
		send_item(KIND_RANK, 16'hFFFF, 11'h7FF, 11'h7FF, 1'b0);
		// small set: depth 2, symbol too wide
		send_item(KIND_LOAD, 16'd3, '0, '0, 1'b0);
		send_item(KIND_LOAD, 16'd1, '0, '0, 1'b1);
		send_item(KIND_RANK, 16'd4, 11'd0, 11'd2, 1'b0);
		send_item(KIND_RANK, 16'd3, 11'd0, 11'd2, 1'b0);
		// all zeros: one level
		send_item(KIND_LOAD, 16'd0, '0, '0, 1'b1);
		send_item(KIND_RANK, 16'd0, 11'd0, 11'd1, 1'b0);
		send_item(KIND_ACCESS, '0, 11'd0, '0, 1'b0);
		drain();
	endtask

	task automatic test_full_set();
		// fill to capacity, then overflow with a last load that still builds
		no_idle = 1;
		for (int i = 0; i < MAX_ELEMENTS; i++)
			send_item(KIND_LOAD, 16'($urandom_range(3)), '0, '0, 1'b0);
		no_idle = 0;
		send_item(KIND_LOAD, 16'd2, '0, '0, 1'b1);
		send_item(KIND_RANK, held_values[0], 11'd0, 11'd1024, 1'b0);
		send_item(KIND_ACCESS, '0, 11'd1023, '0, 1'b0);
		send_item(KIND_ACCESS, '0, 11'd1024, '0, 1'b0);
		drain();
	endtask

	task automatic test_backpressure();
		load_set(12, 255);
		rsp_hold = 200;
		for (int i = 0; i < 8; i++) random_query();
		drain();
	endtask

	task automatic test_random(int unsigned items);
		int unsigned sent;
		sent = 0;
		while (sent < items) begin
			int unsigned n;
			n = $urandom_range(3) == 0 ? $urandom_range(40, 1) : $urandom_range(10, 1);
			load_set(n, $urandom_range(1) ? 65535 : (1 << $urandom_range(15)) - 1);
			sent += n;
			if ($urandom_range(9) == 0) random_query();
			for (int q = $urandom_range(12, 2); q > 0; q--) begin
				random_query();
				sent++;
			end
			if ($urandom_range(7) == 0) begin
				no_idle = ~no_idle;
				drain();
			end
		end
		no_idle = 0;
		drain();
	endtask

	// response sink: random stalls, plus a long hold-off when asked
	always @(posedge clk) begin
		if (rsp_hold > 0) begin
			rsp.ready <= 1'b0;
			rsp_hold <= rsp_hold - 1;
		end else
			rsp.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 15);
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected response answer=%0d status=%0d", $realtime,
					rsp.answer, rsp.status);
				failed = 1;
			end else begin
				query_result_t exp_res;
				exp_res = pending_results.pop_front();
				if (rsp.answer !== exp_res.answer || rsp.status !== exp_res.status) begin
					$display("%0t: expected answer=%0d status=%0d, got answer=%0d status=%0d",
						$realtime, exp_res.answer, exp_res.status, rsp.answer, rsp.status);
					failed = 1;
				end
			end
		end
	end

	initial begin
		req.valid = 1'b0;
		req.kind = KIND_NONE;
		req.value = '0;
		req.position = '0;
		req.right_end = '0;
		req.last = 1'b0;
		rsp.ready = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random(400);
		test_full_set();
		repeat (200) @(posedge clk);
		if (!failed && pending_results.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#400ms;
		$display("Mismatches found");
		$finish;
	end
endmodule

// File: wavelet_matrix_access_rank.f
+incdir+src
src/wmar_pkg.sv
src/wmar_req_if.sv
src/wmar_rsp_if.sv
src/wmar_ram.sv
src/wavelet_matrix_access_rank.sv
test/wavelet_matrix_access_rank_tb_if.sv
test/wavelet_matrix_access_rank_tb.sv
